[hdl/digital_input_auto_error_reset_assert.svh]
// Assertion macros for the digital input auto error reset block.
// Included by the top level; expects a clock named i_clk and a reset named i_rst_n.
`ifndef DIGITAL_INPUT_AUTO_ERROR_RESET_ASSERT_SVH
`define DIGITAL_INPUT_AUTO_ERROR_RESET_ASSERT_SVH

// Check a property on every rising clock edge once reset is released.
`define DIRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define DIRE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

[hdl/dire_pkg.sv]
// Shared types and constants for the digital input auto error reset block.
// No dependencies; used by dire_chan, dire_oreg and the top level.
`timescale 1ns / 1ps

package dire_pkg;

    // Fixed field widths.
    localparam int BITS_W     = 8;
    localparam int PAIRS_W    = 4;
    localparam int LATCH_W    = 16;
    localparam int TIMER_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH    = 3'd3;

    // Amount taken off the recovery timer on each tick, and its floor.
    localparam logic signed [TIMER_W-1:0] TICK_MS   = 18'sd4;
    localparam logic signed [TIMER_W-1:0] TIMER_MIN = -18'sd4;

    // Per-channel machine state.
    typedef enum logic [1:0] {
        ST_CHECK    = 2'd0,
        ST_ERROR    = 2'd1,
        ST_RECOVERY = 2'd2
    } t_chan_state;

    // Per-tick control for one channel cell.
    typedef struct packed {
        logic step;       // process this tick
        logic dual;       // pair runs in dual mode
        logic odd;        // odd channel of its pair
        logic qual_self;
        logic qual_other;
        logic act_self;
        logic act_other;
    } t_chan_ctl;

    // Per-tick result of one channel cell.
    typedef struct packed {
        logic reset_flag;
        logic fault;
    } t_chan_res;

endpackage

[hdl/dire_chan.sv]
// One channel's check / error / recovery machine with its latch timer.
// Depends on dire_pkg.
`timescale 1ns / 1ps

module dire_chan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dire_pkg::t_chan_ctl            i_ctl,
    input  logic [dire_pkg::LATCH_W-1:0]   i_latch_time,
    output dire_pkg::t_chan_res            o_res
);
    import dire_pkg::*;

    t_chan_state               r_state, n_state;
    logic signed [TIMER_W-1:0] r_timer, n_timer;
    logic signed [TIMER_W-1:0] w_dec;
    logic                      w_q_ok, w_any_active, w_odd_dual;

    // Combine the bits of both channels when the pair runs in dual mode.
    assign w_q_ok       = i_ctl.dual ? (i_ctl.qual_self & i_ctl.qual_other) : i_ctl.qual_self;
    assign w_any_active = i_ctl.dual ? (i_ctl.act_self | i_ctl.act_other) : i_ctl.act_self;
    assign w_odd_dual   = i_ctl.dual & i_ctl.odd;

    // Recovery decrement, clamped at the floor.
    always_comb begin
        w_dec = r_timer - TICK_MS;
        if (w_dec < TIMER_MIN) begin
            w_dec = TIMER_MIN;
        end
    end

    // Next state, timer and per-tick result.
    always_comb begin
        n_state          = r_state;
        n_timer          = r_timer;
        o_res.reset_flag = 1'b0;
        o_res.fault      = 1'b0;
        if (i_ctl.step) begin
            unique case (r_state)
                ST_CHECK: begin
                    if (!w_odd_dual && !w_q_ok) begin
                        n_state = ST_ERROR;
                    end
                end
                ST_ERROR: begin
                    if (w_odd_dual) begin
                        o_res.fault = 1'b1;
                    end else if (!w_any_active) begin
                        n_timer = $signed({{(TIMER_W-LATCH_W){1'b0}}, i_latch_time});
                        n_state = ST_RECOVERY;
                    end
                end
                ST_RECOVERY: begin
                    n_timer = w_dec;
                    if (w_odd_dual) begin
                        o_res.fault = 1'b1;
                    end else if (w_any_active) begin
                        n_state = ST_ERROR;
                    end else if (w_dec <= $signed({TIMER_W{1'b0}})) begin
                        n_state          = ST_CHECK;
                        o_res.reset_flag = 1'b1;
                    end
                end
                default: begin
                    // Unused state code: report it and hold.
                    o_res.fault = 1'b1;
                end
            endcase
        end
    end

    // State and timer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CHECK;
            r_timer <= '0;
        end else begin
            r_state <= n_state;
            r_timer <= n_timer;
        end
    end

endmodule

[hdl/dire_oreg.sv]
// Result register that holds one beat until the downstream side takes it.
// Depends on dire_pkg.
`timescale 1ns / 1ps

module dire_oreg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [dire_pkg::BITS_W-1:0]  i_flags,
    input  logic                         i_fault,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [dire_pkg::BITS_W-1:0]  o_flags,
    output logic                         o_fault,
    output logic                         o_free
);
    import dire_pkg::*;

    logic              r_valid;
    logic [BITS_W-1:0] r_flags;
    logic              r_fault;

    // The slot can take a new beat when empty or when its beat leaves now.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_fault = r_fault;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= i_flags;
            r_fault <= i_fault;
        end
    end

endmodule

[hdl/digital_input_auto_error_reset.sv]
// Top level of the digital input auto error reset block: configuration registers,
// channel cells and result register. Depends on dire_pkg, dire_chan, dire_oreg.
//
//   Channel   Handshake                 Payload
//   input     i_valid / o_ready         i_qualifier_ok_bits, i_input_active_bits
//   result    o_valid / i_ready         o_reset_flags, o_fault
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One tick per cycle: a beat is taken when the result register is empty or being
// emptied, each enabled cell updates in the cycle its beat is accepted, and the
// result appears in the result register on the next cycle. Synchronous active-low
// reset puts every channel in check with a zero timer and clears the config and
// valid registers; no clearing pass is needed. While the feature is disabled, beats
// are taken and dropped with the state held. Config writes are always ready.
`timescale 1ns / 1ps

module digital_input_auto_error_reset #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [dire_pkg::BITS_W-1:0]     i_qualifier_ok_bits,
    input  logic [dire_pkg::BITS_W-1:0]     i_input_active_bits,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [dire_pkg::BITS_W-1:0]     o_reset_flags,
    output logic                            o_fault,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dire_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dire_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dire_pkg::*;

    `include "digital_input_auto_error_reset_assert.svh"

    logic               r_enable;
    logic [PAIRS_W-1:0] r_dual;
    logic [PAIRS_W-1:0] r_disabled;
    logic [LATCH_W-1:0] r_latch;

    logic               w_accept, w_free, w_cfg_we;
    logic               w_drop;
    logic [BITS_W-1:0]  w_flags;
    logic               w_fault;
    t_chan_ctl          w_ctl [NUM_CHANNELS];
    t_chan_res          w_res [NUM_CHANNELS];

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;
    assign o_ready     = w_free;
    assign w_accept    = i_valid && w_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_dual     <= '0;
            r_disabled <= '0;
            r_latch    <= '0;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                CFG_DUAL:     r_dual     <= i_cfg_data[PAIRS_W-1:0];
                CFG_DISABLED: r_disabled <= i_cfg_data[PAIRS_W-1:0];
                CFG_LATCH:    r_latch    <= i_cfg_data[LATCH_W-1:0];
                default: begin
                    // Writes beyond the register list are ignored.
                end
            endcase
        end
    end

    // Channel cells; each reads its own bits and its pair partner's bits.
    for (genvar gi = 0; gi < NUM_CHANNELS; gi++) begin : g_chan
        localparam int PAIR  = gi / 2;
        localparam int OTHER = gi ^ 1;

        assign w_ctl[gi].step       = w_accept && r_enable && !r_disabled[PAIR];
        assign w_ctl[gi].dual       = r_dual[PAIR];
        assign w_ctl[gi].odd        = ((gi % 2) != 0);
        assign w_ctl[gi].qual_self  = i_qualifier_ok_bits[gi];
        assign w_ctl[gi].qual_other = i_qualifier_ok_bits[OTHER];
        assign w_ctl[gi].act_self   = i_input_active_bits[gi];
        assign w_ctl[gi].act_other  = i_input_active_bits[OTHER];

        dire_chan u_chan (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[gi]),
            .i_latch_time (r_latch),
            .o_res        (w_res[gi])
        );
    end

    // Gather the reset flags and the fault bit of all channels.
    always_comb begin
        w_flags = '0;
        w_fault = 1'b0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            w_flags[k] = w_res[k].reset_flag;
            w_fault    = w_fault | w_res[k].fault;
        end
    end

    // Result register: a beat is produced only while the feature is enabled.
    dire_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && r_enable),
        .i_flags (w_flags),
        .i_fault (w_fault),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_flags (o_reset_flags),
        .o_fault (o_fault),
        .o_free  (w_free)
    );

    // A beat taken while disabled, with no result leaving in the same cycle.
    assign w_drop = w_accept && !r_enable && !(o_valid && i_ready);

    // A full result register that is stalled must block the input.
    `DIRE_ASSERT(a_stall_blocks, (o_valid && !i_ready) |-> !o_ready, "stall not applied")
    // An accepted beat while enabled always yields a result.
    `DIRE_ASSERT_NEXT(a_enabled_result, w_accept && r_enable, o_valid, "result missing")
    // A beat taken while disabled leaves the result side untouched.
    `DIRE_ASSERT_NEXT(a_disabled_drop, w_drop, o_valid == $past(o_valid), "beat made result")
    // Flags above the channel count are never set.
    `DIRE_ASSERT(a_flags_range, o_valid |-> ((o_reset_flags >> NUM_CHANNELS) == '0), "stray flag")

endmodule

[tb/digital_input_auto_error_reset_test.sv]
// Testbench for digital_input_auto_error_reset: directed and random ticks, checked
// beat by beat against a channel-machine predictor held in a scoreboard class.
// Depends on dire_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module digital_input_auto_error_reset_test;

    localparam int CHANNELS     = dire_pkg::BITS_W;
    localparam int RANDOM_TICKS = 1800;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE       = 4;

    typedef logic [dire_pkg::BITS_W-1:0] t_chan_bits;

    typedef struct {
        t_chan_bits flags;
        logic       fault;
    } t_tick_result;

    // Predicts the reset flags and fault of every enabled tick and checks the results.
    class reset_flag_scoreboard;
        bit                        enable;
        logic [3:0]                dual_pairs;
        logic [3:0]                off_pairs;
        logic [15:0]               latch_ms;
        dire_pkg::t_chan_state     chan_state [dire_pkg::BITS_W];
        logic signed [17:0]        chan_timer [dire_pkg::BITS_W];
        t_tick_result              expected_q [$];
        int                        mismatches;

        function new();
            enable     = 1'b0;
            dual_pairs = '0;
            off_pairs  = '0;
            latch_ms   = '0;
            mismatches = 0;
            foreach (chan_state[i]) begin
                chan_state[i] = dire_pkg::ST_CHECK;
                chan_timer[i] = '0;
            end
        endfunction

        function void write_reg(logic [dire_pkg::CFG_IDX_W-1:0] idx,
                                logic [dire_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dire_pkg::CFG_ENABLE:   enable     = data[0];
                dire_pkg::CFG_DUAL:     dual_pairs = data[3:0];
                dire_pkg::CFG_DISABLED: off_pairs  = data[3:0];
                dire_pkg::CFG_LATCH:    latch_ms   = data[15:0];
                default: ;
            endcase
        endfunction

        // Advance every channel machine of an enabled pair by one tick and queue the expected beat.
        function void note_tick(t_chan_bits qual, t_chan_bits act);
            t_tick_result res;
            int           pair;
            int           other;
            bit           dual_m;
            bit           odd_dual;
            bit           q_ok;
            bit           quiet;
            bit           busy;
            if (!enable) return;
            res.flags = '0;
            res.fault = 1'b0;
            for (int i = 0; i < dire_pkg::BITS_W; i++) begin
                pair  = i / 2;
                other = i ^ 1;
                if (off_pairs[pair]) continue;
                dual_m   = dual_pairs[pair];
                odd_dual = dual_m && (i % 2 == 1);
                if (dual_m) begin
                    q_ok  = qual[i] && qual[other];
                    quiet = !act[i] && !act[other];
                    busy  = act[i] || act[other];
                end else begin
                    q_ok  = qual[i];
                    quiet = !act[i];
                    busy  = act[i];
                end
                case (chan_state[i])
                    dire_pkg::ST_CHECK: begin
                        if (!odd_dual && !q_ok) chan_state[i] = dire_pkg::ST_ERROR;
                    end
                    dire_pkg::ST_ERROR: begin
                        if (odd_dual) begin
                            res.fault = 1'b1;
                        end else if (quiet) begin
                            chan_timer[i] = $signed({2'b00, latch_ms});
                            chan_state[i] = dire_pkg::ST_RECOVERY;
                        end
                    end
                    dire_pkg::ST_RECOVERY: begin
                        // The timer runs down even when the channel only reports a fault.
                        chan_timer[i] = chan_timer[i] - dire_pkg::TICK_MS;
                        if (chan_timer[i] < dire_pkg::TIMER_MIN)
                            chan_timer[i] = dire_pkg::TIMER_MIN;
                        if (odd_dual) begin
                            res.fault = 1'b1;
                        end else if (busy) begin
                            chan_state[i] = dire_pkg::ST_ERROR;
                        end else if (chan_timer[i] <= 0) begin
                            chan_state[i] = dire_pkg::ST_CHECK;
                            res.flags[i]  = 1'b1;
                        end
                    end
                    default: res.fault = 1'b1;
                endcase
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(t_chan_bits flags, logic fault);
            t_tick_result exp_res;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: flags=%h fault=%b",
                             $realtime, flags, fault);
                return;
            end
            exp_res = expected_q.pop_front();
            if (flags !== exp_res.flags || fault !== exp_res.fault) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result beat wrong: expected flags=%h fault=%b,",
                              " got flags=%h fault=%b"},
                             $realtime, exp_res.flags, exp_res.fault, flags, fault);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    t_chan_bits                      i_qualifier_ok_bits;
    t_chan_bits                      i_input_active_bits;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    t_chan_bits                      o_reset_flags;
    logic                            o_fault;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [dire_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [dire_pkg::CFG_DATA_W-1:0] i_cfg_data;

    reset_flag_scoreboard sb;
    bit                   bursts_on = 1'b1;
    int                   ready_hold = 0;
    int                   stall_cycles = 0;

    digital_input_auto_error_reset #(
        .NUM_CHANNELS(CHANNELS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_qualifier_ok_bits(i_qualifier_ok_bits),
        .i_input_active_bits(i_input_active_bits),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_reset_flags      (o_reset_flags),
        .o_fault            (o_fault),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: random stall bursts while bursts are on.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_ready = 1'b0;
        end else if (bursts_on && $urandom_range(0, 4) == 0) begin
            ready_hold = $urandom_range(1, 4) - 1;
            i_ready = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    // Watch every handshake at the rising edge; results are checked before the
    // new input beat is noted so that they pair with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (o_valid && i_ready) sb.check_result(o_reset_flags, o_fault);
            if (i_valid && o_ready) sb.note_tick(i_qualifier_ok_bits, i_input_active_bits);
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_chan_bits rand_mask(int pct);
        t_chan_bits m;
        for (int b = 0; b < dire_pkg::BITS_W; b++)
            m[b] = ($urandom_range(0, 99) < pct);
        return m;
    endfunction

    // Drive one tick beat; entered and left just after a falling edge.
    task automatic send_tick(t_chan_bits qual, t_chan_bits act);
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid             = 1'b1;
        i_qualifier_ok_bits = qual;
        i_input_active_bits = act;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [dire_pkg::CFG_IDX_W-1:0] idx,
                             logic [dire_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Let every expected beat arrive, then give the block time to finish
    // ticks that produce no result.
    task automatic drain();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic configure(bit en, logic [3:0] dual, logic [3:0] off, logic [15:0] latch);
        drain();
        write_reg(dire_pkg::CFG_ENABLE, {15'd0, en});
        write_reg(dire_pkg::CFG_DUAL, {12'd0, dual});
        write_reg(dire_pkg::CFG_DISABLED, {12'd0, off});
        write_reg(dire_pkg::CFG_LATCH, latch);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int         ticks_done;
        int         phase_idx;
        int         n;
        int         qbad_pct;
        int         act_pct;
        bit         en;
        logic [3:0] dual;
        logic [3:0] off;
        logic [15:0] latch;

        sb                  = new();
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_qualifier_ok_bits = '0;
        i_input_active_bits = '0;
        i_cfg_valid         = 1'b0;
        i_cfg_index         = dire_pkg::CFG_ENABLE;
        i_cfg_data          = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full error, hold, recovery and reset on all channels; then odd channels
        // are left in recovery for the dual-mode fault below.
        configure(1'b1, 4'h0, 4'h0, 16'd4);
        send_tick(8'hFF, 8'h00);
        send_tick(8'h00, 8'hFF);
        send_tick(8'hFF, 8'hFF);
        send_tick(8'hFF, 8'h00);
        send_tick(8'hFF, 8'h00);
        send_tick(8'h55, 8'hFF);
        send_tick(8'hFF, 8'hAA);
        send_tick(8'hFF, 8'h55);

        // Dual mode on every pair with zero latch time: odd channels caught in
        // recovery fault while their timers run down to the floor.
        configure(1'b1, 4'hF, 4'h0, 16'd0);
        send_tick(8'hFF, 8'h00);
        send_tick(8'hFF, 8'h00);
        send_tick(8'hFE, 8'h00);
        send_tick(8'hFF, 8'h00);
        send_tick(8'hFF, 8'h00);
        send_tick(8'h7F, 8'h00);
        send_tick(8'hFF, 8'h80);
        send_tick(8'hFF, 8'h00);
        send_tick(8'hFF, 8'h40);

        // Feature off: beats are dropped and the state is held.
        configure(1'b0, 4'h0, 4'h5, 16'd8);
        send_tick(8'h00, 8'hFF);
        send_tick(8'h00, 8'h00);
        configure(1'b1, 4'h0, 4'h5, 16'd8);
        send_tick(8'h00, 8'hFF);
        send_tick(8'hFF, 8'h00);
        send_tick(8'hFF, 8'h00);

        // Random phases, mostly quiet enough for channels to run full recoveries.
        ticks_done = 0;
        phase_idx  = 0;
        while (ticks_done < RANDOM_TICKS) begin
            if (ticks_done >= RANDOM_TICKS * 5 / 6)
                bursts_on = 1'b0;
            else
                bursts_on = ($urandom_range(0, 3) != 0);
            if (phase_idx == 0) begin
                en = 1'b1; dual = 4'hF; off = 4'h0; latch = 16'hFFFF;
            end else if (phase_idx == 1) begin
                en = 1'b1; dual = 4'h0; off = 4'hF; latch = 16'd0;
            end else begin
                en = ($urandom_range(0, 7) != 0);
                case ($urandom_range(0, 3))
                    0:       dual = 4'h0;
                    1:       dual = 4'hF;
                    default: dual = 4'($urandom_range(0, 15));
                endcase
                case ($urandom_range(0, 5))
                    0, 1, 2: off = 4'h0;
                    3:       off = 4'hF;
                    default: off = 4'($urandom_range(0, 15));
                endcase
                case ($urandom_range(0, 9))
                    0:       latch = 16'd0;
                    1:       latch = 16'hFFFF;
                    default: latch = 16'($urandom_range(0, 48));
                endcase
            end
            configure(en, dual, off, latch);
            case ($urandom_range(0, 5))
                0, 1:    qbad_pct = 2;
                2, 3:    qbad_pct = 8;
                4:       qbad_pct = 30;
                default: qbad_pct = 60;
            endcase
            case ($urandom_range(0, 5))
                0, 1:    act_pct = 3;
                2, 3:    act_pct = 10;
                4:       act_pct = 40;
                default: act_pct = 90;
            endcase
            n = en ? $urandom_range(60, 200) : $urandom_range(5, 20);
            repeat (n) begin
                send_tick(~rand_mask(qbad_pct), rand_mask(act_pct));
                if (en) ticks_done++;
            end
            phase_idx++;
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[digital_input_auto_error_reset.f]
+incdir+hdl
hdl/dire_pkg.sv
hdl/dire_chan.sv
hdl/dire_oreg.sv
hdl/digital_input_auto_error_reset.sv
tb/digital_input_auto_error_reset_test.sv
